// File: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, codes and control/status bundles for the prime test and
// search block.
// ----------------------------------------------------------------------------
package pts_pkg;

	// operand and answer width
	localparam int VAL_W = 32;
	// trial divisor width, enough for divisors up to sqrt(2^VAL_W) plus a step
	localparam int DIV_W = VAL_W / 2 + 2;
	// running square of the trial divisor
	localparam int SQ_W = 2 * DIV_W;
	// bit-serial divider step counter
	localparam int CNT_W = $clog2(VAL_W);

	// command codes (the unused code is decoded as test)
	localparam logic [1:0] CMD_TEST = 2'd0;
	localparam logic [1:0] CMD_NEXT = 2'd1;
	localparam logic [1:0] CMD_PREV = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOPREV = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;

	// divisor selection for the modulo unit
	typedef enum logic {
		DIV_BYD,
		DIV_BYD2
	} div_sel_t;

	// kind of result to post
	typedef enum logic [2:0] {
		RES_PRIME,
		RES_COMP,
		RES_TWO,
		RES_NOPREV,
		RES_OVF
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     init_d;
		logic     step_d;
		logic     step_p;
		logic     div_start;
		div_sel_t div_sel;
		logic     post;
		res_t     res;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_next;
		logic is_prev;
		logic v_le1;
		logic v_eq2;
		logic p_le1;
		logic p_le3;
		logic p_even;
		logic p_div3;
		logic p_top;
		logic sq_gt_p;
		logic div_done;
		logic rem_zero;
		logic out_full;
	} dp_stat_t;

endpackage

// File: hdl/pts_div.sv
// ----------------------------------------------------------------------------
// pts_div
// Bit-serial restoring modulo unit: one dividend bit per cycle, remainder
// ready with a one-cycle done pulse once all VAL_W dividend bits are in.
// ----------------------------------------------------------------------------
module pts_div
	import pts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-1:0] rem,
	output logic             done
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// shift in the next dividend bit and try one subtraction
	assign trial = {rem_q, dvd_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

// File: hdl/pts_dp.sv
// ----------------------------------------------------------------------------
// pts_dp
// Datapath: candidate register, residue check by 3, trial divisor and its
// square, the modulo unit and the output register.
// ----------------------------------------------------------------------------
module pts_dp
	import pts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  logic [1:0]       in_cmd,
	input  logic [VAL_W-1:0] in_value,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [VAL_W-1:0] out_answer,
	output logic             out_is_prime,
	output logic [1:0]       out_status,
	output dp_stat_t         stat
);

	logic [1:0]       cmd_q;
	logic             v_le1_q;
	logic             v_eq2_q;
	logic [VAL_W-1:0] p_q;
	logic [DIV_W-1:0] d_q;
	logic [SQ_W-1:0]  sq_q;
	logic [DIV_W-1:0] divisor;
	logic [DIV_W-1:0] rem;
	logic             div_done;
	logic             is_next;
	logic             is_prev;
	logic             out_valid_q;
	logic [VAL_W-1:0] answer_q;
	logic             is_prime_q;
	logic [1:0]       status_q;
	logic [16:0]      m3_a;
	logic [9:0]       m3_b;
	logic [6:0]       m3_c;
	logic [5:0]       m3_d;
	logic [4:0]       m3_e;
	logic [3:0]       m3_f;

	assign is_next = (cmd_q == CMD_NEXT);
	assign is_prev = (cmd_q == CMD_PREV);

	// operand capture and candidate stepping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			v_le1_q <= in_value <= VAL_W'(1);
			v_eq2_q <= in_value == VAL_W'(2);
			if (in_cmd == CMD_NEXT)
				p_q <= in_value | VAL_W'(1);
			else if (in_cmd == CMD_PREV && !in_value[0])
				p_q <= in_value - VAL_W'(1);
			else
				p_q <= in_value;
		end else if (cmd.step_p) begin
			if (is_next)
				p_q <= p_q + VAL_W'(2);
			else
				p_q <= p_q - VAL_W'(2);
		end
	end

	// residue by 3: fold halves, 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3
	always_comb begin
		m3_a = 17'(p_q[VAL_W-1:VAL_W/2]) + 17'(p_q[VAL_W/2-1:0]);
		m3_b = 10'(m3_a[16:8]) + 10'(m3_a[7:0]);
		m3_c = 7'(m3_b[9:4]) + 7'(m3_b[3:0]);
		m3_d = 6'(m3_c[6:2]) + 6'(m3_c[1:0]);
		m3_e = 5'(m3_d[5:2]) + 5'(m3_d[1:0]);
		m3_f = 4'(m3_e[4:2]) + 4'(m3_e[1:0]);
	end

	// trial divisor 6k-1 and its square, (d+6)^2 = d^2 + 12d + 36
	always_ff @(posedge clk) begin
		if (cmd.init_d) begin
			d_q  <= DIV_W'(5);
			sq_q <= SQ_W'(25);
		end else if (cmd.step_d) begin
			d_q  <= d_q + DIV_W'(6);
			sq_q <= sq_q + SQ_W'({d_q, 3'b000}) + SQ_W'({d_q, 2'b00}) + SQ_W'(36);
		end
	end

	// divisor selection
	always_comb begin
		case (cmd.div_sel)
			DIV_BYD:  divisor = d_q;
			DIV_BYD2: divisor = d_q + DIV_W'(2);
			default:  divisor = d_q;
		endcase
	end

	pts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (p_q),
		.divisor  (divisor),
		.rem      (rem),
		.done     (div_done)
	);

	// output register, holds one finished result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.post)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			case (cmd.res)
				RES_PRIME: begin
					answer_q   <= p_q;
					is_prime_q <= 1'b1;
					status_q   <= ST_OK;
				end
				RES_COMP: begin
					answer_q   <= p_q;
					is_prime_q <= 1'b0;
					status_q   <= ST_OK;
				end
				RES_TWO: begin
					answer_q   <= VAL_W'(2);
					is_prime_q <= 1'b1;
					status_q   <= ST_OK;
				end
				RES_NOPREV: begin
					answer_q   <= '0;
					is_prime_q <= 1'b0;
					status_q   <= ST_NOPREV;
				end
				RES_OVF: begin
					answer_q   <= '0;
					is_prime_q <= 1'b0;
					status_q   <= ST_OVF;
				end
				default: begin
					answer_q   <= '0;
					is_prime_q <= 1'b0;
					status_q   <= ST_OK;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_answer   = answer_q;
	assign out_is_prime = is_prime_q;
	assign out_status   = status_q;

	// status back to the controller
	always_comb begin
		stat.is_next  = is_next;
		stat.is_prev  = is_prev;
		stat.v_le1    = v_le1_q;
		stat.v_eq2    = v_eq2_q;
		stat.p_le1    = p_q <= VAL_W'(1);
		stat.p_le3    = p_q <= VAL_W'(3);
		stat.p_even   = !p_q[0];
		stat.p_div3   = m3_f inside {4'd0, 4'd3, 4'd6, 4'd9};
		stat.p_top    = &p_q[VAL_W-1:1];
		stat.sq_gt_p  = sq_q > SQ_W'(p_q);
		stat.div_done = div_done;
		stat.rem_zero = (rem == '0);
		stat.out_full = out_valid_q;
	end

endmodule

// File: hdl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Controller: screens the special cases, runs the trial division sequence
// over the 6k-1/6k+1 divisor pairs and steps the candidate for searches.
// ----------------------------------------------------------------------------
module pts_ctrl
	import pts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCREEN,
		S_TESTP,
		S_CHK,
		S_WAITA,
		S_WAITB,
		S_COMP,
		S_DONE
	} state_t;

	state_t state_q;
	res_t   res_q;
	logic   is_test;

	assign is_test  = !stat.is_next && !stat.is_prev;
	assign in_ready = (state_q == S_IDLE);

	// state and held result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_COMP;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SCREEN;
				end
				S_SCREEN: begin
					if (stat.is_next && (stat.v_le1 || stat.v_eq2)) begin
						res_q   <= RES_TWO;
						state_q <= S_DONE;
					end else if (stat.is_prev && stat.v_le1) begin
						res_q   <= RES_NOPREV;
						state_q <= S_DONE;
					end else if (stat.is_prev && stat.v_eq2) begin
						res_q   <= RES_TWO;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TESTP;
					end
				end
				S_TESTP: begin
					if (stat.p_le1) begin
						state_q <= S_COMP;
					end else if (stat.p_le3) begin
						res_q   <= RES_PRIME;
						state_q <= S_DONE;
					end else if (stat.p_even || stat.p_div3) begin
						state_q <= S_COMP;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (stat.sq_gt_p) begin
						res_q   <= RES_PRIME;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WAITA;
					end
				end
				S_WAITA: begin
					if (stat.div_done)
						state_q <= stat.rem_zero ? S_COMP : S_WAITB;
				end
				S_WAITB: begin
					if (stat.div_done)
						state_q <= stat.rem_zero ? S_COMP : S_CHK;
				end
				S_COMP: begin
					if (is_test) begin
						res_q   <= RES_COMP;
						state_q <= S_DONE;
					end else if (stat.is_next && stat.p_top) begin
						res_q   <= RES_OVF;
						state_q <= S_DONE;
					end else begin
						state_q <= S_TESTP;
					end
				end
				S_DONE: begin
					if (!stat.out_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.div_sel   = DIV_BYD;
		cmd.res       = res_q;
		case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_TESTP: cmd.init_d = !stat.p_le1 && !stat.p_le3 && !stat.p_even && !stat.p_div3;
			S_CHK: begin
				cmd.div_start = !stat.sq_gt_p;
				cmd.div_sel   = DIV_BYD;
			end
			S_WAITA: begin
				cmd.div_start = stat.div_done && !stat.rem_zero;
				cmd.div_sel   = DIV_BYD2;
			end
			S_WAITB: cmd.step_d = stat.div_done && !stat.rem_zero;
			S_COMP:  cmd.step_p = !is_test && !(stat.is_next && stat.p_top);
			S_DONE:  cmd.post = !stat.out_full;
			default: cmd.load = 1'b0;
		endcase
	end

endmodule

// File: hdl/prime_test_and_search.sv
// ----------------------------------------------------------------------------
// prime_test_and_search
// Primality test and next/previous prime search by 6k+-1 trial division.
//
// Usage:
//   Input channel s_*: s_tdata carries the 32-bit operand, s_tuser the
//   command (test, next prime at or above, previous prime at or below;
//   the unused code tests). One transaction in gives one transaction out.
//   Output channel m_*: m_tdata carries the answer, m_tuser the prime flag
//   and the status (ok, no previous prime, next prime overflows).
//   Items are handled one at a time; s_tready is high only while idle.
//   Factors 2 and 3 are screened combinationally; each divisor pair
//   6k-1/6k+1 up to sqrt(operand) then takes up to two remainders from the
//   bit-serial modulo unit (one bit per cycle); a search repeats that per
//   odd candidate. Special cases and tests of even operands or multiples
//   of 3 post their result without using the modulo unit.
//   The finished result sits in an output register; while the receiver
//   stalls, the block holds it there and takes the next operand, but posts
//   that operand's result only once the register is free.
//   Reset clears the controller, the modulo unit's control and the output valid; no other state.
// ----------------------------------------------------------------------------
module prime_test_and_search
	import pts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // [31:0] value
	input  logic [1:0]       s_tuser,   // [1:0] cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,   // [31:0] answer
	output logic [2:0]       m_tuser    // [0] is_prime, [2:1] status
);

	ctrl_cmd_t  cmd;
	dp_stat_t   stat;
	logic       is_prime;
	logic [1:0] status;

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_cmd       (s_tuser),
		.in_value     (s_tdata),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_answer   (m_tdata),
		.out_is_prime (is_prime),
		.out_status   (status),
		.stat         (stat)
	);

	// pack the result flags
	assign m_tuser = {status, is_prime};

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prime_test_and_search. A short table of directed
// operands walks zero, one, two, the 32-bit extremes, squares of the first
// trial divisors, the spare command and the no-previous and overflow cases.
// Random operands follow, mostly small or medium, with wide operands that the
// block can rule out quickly. Accepted transactions are scored in order against
// typed answers or a trial-division model; both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench
	import pts_pkg::*;
();

	// spare command code, decoded by the block as a test
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam int RANDOM_ITEMS    = 75;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TAIL_CYCLES     = 100;
	localparam int QUIET_LIMIT     = 4000000;

	typedef struct packed {
		logic [VAL_W-1:0] answer;
		logic             is_prime;
		logic [1:0]       status;
	} prime_answer_t;

	typedef struct {
		logic [1:0]    cmd;
		logic [31:0]   value;
		bit            typed;
		prime_answer_t known;
	} probe_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata;   // [31:0] value
	logic [1:0]       s_tuser;   // [1:0] cmd
	logic             m_tvalid;
	logic             m_tready;
	logic [VAL_W-1:0] m_tdata;   // [31:0] answer
	logic [2:0]       m_tuser;   // [0] is_prime, [2:1] status

	prime_answer_t awaited_answers[$];
	probe_row_t    probe_rows[$];
	int unsigned   mismatch_count = 0;
	int unsigned   quiet_cycles = 0;
	int            burst_left = 0;
	bit            hold_off_pending = 1'b0;

	prime_test_and_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// trial division by 2, 3, then 6k-1 and 6k+1 up to the square root
	function automatic bit trial_prime(logic [63:0] n);
		logic [63:0] d;
		if (n <= 64'd1)
			return 1'b0;
		if (n <= 64'd3)
			return 1'b1;
		if ((n % 64'd2) == 64'd0 || (n % 64'd3) == 64'd0)
			return 1'b0;
		for (d = 64'd5; d <= n / d; d += 64'd6) begin
			if ((n % d) == 64'd0 || (n % (d + 64'd2)) == 64'd0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// answer, prime flag and status for one command and operand
	function automatic prime_answer_t prime_search(logic [1:0] cmd, logic [31:0] value);
		prime_answer_t r;
		logic [63:0]   v;
		logic [63:0]   p;
		logic [63:0]   top;
		bit            found;
		top = (64'd1 << VAL_W) - 64'd1;
		v = {32'd0, value} & top;
		r.answer = '0;
		r.is_prime = 1'b0;
		r.status = ST_OK;
		case (cmd)
			CMD_NEXT: begin
				if (v <= 64'd2) begin
					r.answer = 2;
					r.is_prime = 1'b1;
				end else begin
					p = v | 64'd1;
					found = 1'b1;
					// odd candidates upward until one is prime or the top is passed
					while (found && !trial_prime(p)) begin
						if (p > top - 64'd2)
							found = 1'b0;
						else
							p += 64'd2;
					end
					if (found) begin
						r.answer = p[VAL_W-1:0];
						r.is_prime = 1'b1;
					end else begin
						r.status = ST_OVF;
					end
				end
			end
			CMD_PREV: begin
				if (v <= 64'd1) begin
					r.status = ST_NOPREV;
				end else if (v == 64'd2) begin
					r.answer = 2;
					r.is_prime = 1'b1;
				end else begin
					p = v;
					if (p[0] == 1'b0)
						p -= 64'd1;
					while (p > 64'd3 && !trial_prime(p))
						p -= 64'd2;
					r.answer = p[VAL_W-1:0];
					r.is_prime = 1'b1;
				end
			end
			default: begin
				r.answer = v[VAL_W-1:0];
				r.is_prime = trial_prime(v);
			end
		endcase
		return r;
	endfunction

	function automatic void add_probe(logic [1:0] cmd, logic [31:0] value, bit typed,
			logic [31:0] answer, logic is_prime, logic [1:0] status);
		probe_row_t row;
		row.cmd = cmd;
		row.value = value;
		row.typed = typed;
		row.known.answer = answer;
		row.known.is_prime = is_prime;
		row.known.status = status;
		probe_rows.push_back(row);
	endfunction

	// offer one operand in the current burst, wait for the transaction
	task automatic offer_item(logic [1:0] cmd, logic [31:0] value, prime_answer_t want);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		awaited_answers.push_back(want);
		burst_left--;
	endtask

	// receiver: alternating ready and stall runs, plus one long hold-off
	initial begin
		int   run_left;
		logic level;
		run_left = 0;
		level = 1'b0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					level = !level;
					if (level)
						run_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
					else
						run_left = $urandom_range(1, 5);
				end
				run_left--;
				m_tready <= level;
			end
		end
	end

	// scoreboard: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		prime_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_answers.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result answer=%h is_prime=%b status=%0d",
					$time, m_tdata, m_tuser[0], m_tuser[2:1]);
			end else begin
				want = awaited_answers.pop_front();
				if (m_tdata !== want.answer || m_tuser[0] !== want.is_prime ||
						m_tuser[2:1] !== want.status) begin
					mismatch_count++;
					$display("%0t: expected %h/%b/%0d, actual %h/%b/%0d",
						$time, want.answer, want.is_prime, want.status,
						m_tdata, m_tuser[0], m_tuser[2:1]);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		probe_row_t    row;
		prime_answer_t want;
		logic [1:0]    cmd;
		logic [31:0]   value;
		int            pick;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TEST;

		//        cmd        value          typed answer        prime status
		add_probe(CMD_TEST,  32'd0,         1'b1, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'd1,         1'b1, 32'd1,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'd2,         1'b1, 32'd2,        1'b1, ST_OK);
		add_probe(CMD_TEST,  32'd3,         1'b1, 32'd3,        1'b1, ST_OK);
		add_probe(CMD_TEST,  32'd4,         1'b1, 32'd4,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'd25,        1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'd49,        1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'd65521,     1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'hFFFF_FFFF, 1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_TEST,  32'h8000_0000, 1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_SPARE, 32'd7,         1'b1, 32'd7,        1'b1, ST_OK);
		add_probe(CMD_SPARE, 32'd9,         1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_NEXT,  32'd0,         1'b1, 32'd2,        1'b1, ST_OK);
		add_probe(CMD_NEXT,  32'd1,         1'b1, 32'd2,        1'b1, ST_OK);
		add_probe(CMD_NEXT,  32'd2,         1'b1, 32'd2,        1'b1, ST_OK);
		add_probe(CMD_NEXT,  32'd3,         1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_NEXT,  32'd24,        1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_NEXT,  32'hFFFF_FFFF, 1'b1, 32'd0,        1'b0, ST_OVF);
		add_probe(CMD_NEXT,  32'hFFFF_FFFE, 1'b1, 32'd0,        1'b0, ST_OVF);
		add_probe(CMD_PREV,  32'd0,         1'b1, 32'd0,        1'b0, ST_NOPREV);
		add_probe(CMD_PREV,  32'd1,         1'b1, 32'd0,        1'b0, ST_NOPREV);
		add_probe(CMD_PREV,  32'd2,         1'b1, 32'd2,        1'b1, ST_OK);
		add_probe(CMD_PREV,  32'd3,         1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_PREV,  32'd4,         1'b0, 32'd0,        1'b0, ST_OK);
		add_probe(CMD_PREV,  32'd120,       1'b0, 32'd0,        1'b0, ST_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (probe_rows[i]) begin
			row = probe_rows[i];
			want = row.typed ? row.known : prime_search(row.cmd, row.value);
			offer_item(row.cmd, row.value, want);
		end

		// random operands: mostly small and medium, wide ones that fail fast
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 0)
				hold_off_pending = 1'b1;
			// let the block drain completely once
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (awaited_answers.size() != 0);
				burst_left = 0;
			end
			pick = $urandom_range(0, 9);
			if (pick < 4)
				cmd = CMD_TEST;
			else if (pick < 7)
				cmd = CMD_NEXT;
			else if (pick < 9)
				cmd = CMD_PREV;
			else
				cmd = CMD_SPARE;
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				value = $urandom_range(0, 4095);
			end else if (pick < 16) begin
				value = $urandom_range(4096, 1 << 18);
			end else if (pick < 18) begin
				value = $urandom;
				value[0] = 1'b0;
				cmd = ($urandom_range(0, 1) == 0) ? CMD_TEST : CMD_SPARE;
			end else if (pick < 19) begin
				value = 32'd3 * $urandom_range(0, 32'h5555_5555);
				cmd = ($urandom_range(0, 1) == 0) ? CMD_TEST : CMD_SPARE;
			end else begin
				value = $urandom_range(0, 3);
			end
			offer_item(cmd, value, prime_search(cmd, value));
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (awaited_answers.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
